FILE: hdl/dmat_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dmat_pkg
// Shared constants and types for the dual moving average and trend block.
// -----------------------------------------------------------------------------
package dmat_pkg;

   localparam int WINDOW   = 120;
   localparam int SAMPLE_W = 12;
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int REM_W    = CNT_W + 1;
   localparam int STEP_W   = $clog2(SUM_W + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [SLOT_W-1:0]          slot_type;
   typedef logic [CNT_W-1:0]           count_type;

   typedef struct packed {
      logic      start;
      slot_type  slot;
      logic      full;
      count_type divisor;
      logic      have_last;
   } lane_start_type;

   typedef struct packed {
      logic       done;
      sample_type average;
      logic       rising;
      logic       turn;
   } lane_result_type;

endpackage
`default_nettype wire

FILE: hdl/dmat_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dmat_if
// Sample and result channels of the dual moving average block.
// -----------------------------------------------------------------------------
interface dmat_req_if import dmat_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type front_sample;
   sample_type rear_sample;

   modport source (output valid, front_sample, rear_sample, input ready);
   modport sink (input valid, front_sample, rear_sample, output ready);
endinterface

interface dmat_rsp_if import dmat_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type front_average;
   sample_type rear_average;
   logic       front_rising;
   logic       rear_rising;
   logic       front_turn;
   logic       rear_turn;

   modport source (output valid, front_average, rear_average, front_rising,
                   rear_rising, front_turn, rear_turn, input ready);
   modport sink (input valid, front_average, rear_average, front_rising,
                 rear_rising, front_turn, rear_turn, output ready);
endinterface
`default_nettype wire

FILE: hdl/dmat_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dmat_ram
// Generic single write port, single read port RAM with registered read.
// -----------------------------------------------------------------------------
module dmat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/dmat_lane.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dmat_lane
// One channel: sample ring, running sum, bit-serial divide and trend flags.
// -----------------------------------------------------------------------------
module dmat_lane import dmat_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lane_start_type  ctl,
   input  wire sample_type      sample,
   output      lane_result_type res
);

   typedef enum logic [2:0] {
      IDLE,
      ACCUM,
      MAGN,
      DIVIDE,
      FINISH
   } state_type;

   state_type              state_ff;
   sample_type             sample_ff;
   slot_type               slot_ff;
   logic                   full_ff;
   count_type              div_ff;
   logic                   have_ff;
   sum_type                sum_ff;
   logic [SUM_W-1:0]       quo_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   neg_ff;
   sample_type             last_avg_ff;
   logic                   last_rising_ff;
   lane_result_type        res_ff;

   logic [SAMPLE_W-1:0]    ram_rd_data;
   sample_type             old_sample;
   sum_type                sum_in;
   logic [REM_W-1:0]       rem_shift;
   logic [REM_W-1:0]       div_ext;
   logic                   fits;
   logic [SUM_W-1:0]       quo_signed;
   sample_type             avg_in;
   logic                   rising_in;

   dmat_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ACCUM),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (state_ff == IDLE && ctl.start),
      .rd_addr (ctl.slot),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      old_sample = sample_type'(ram_rd_data);
      sum_in     = sum_ff + SUM_W'(sample_ff);
      if (full_ff) begin
         sum_in = sum_in - SUM_W'(old_sample);
      end
      rem_shift  = {rem_ff[REM_W-2:0], quo_ff[SUM_W-1]};
      div_ext    = REM_W'(div_ff);
      fits       = (rem_shift >= div_ext);
      quo_signed = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
      avg_in     = sample_type'(quo_signed[SAMPLE_W-1:0]);
      rising_in  = !have_ff || (avg_in >= last_avg_ff);
   end

   always_ff @(posedge clock) begin
      res_ff.done <= 1'b0;
      case (state_ff)
         IDLE: begin
            if (ctl.start) begin
               sample_ff <= sample;
               slot_ff   <= ctl.slot;
               full_ff   <= ctl.full;
               div_ff    <= ctl.divisor;
               have_ff   <= ctl.have_last;
               state_ff  <= ACCUM;
            end
         end
         ACCUM: begin
            sum_ff   <= sum_in;
            state_ff <= MAGN;
         end
         MAGN: begin
            neg_ff   <= sum_ff[SUM_W-1];
            quo_ff   <= sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
            rem_ff   <= '0;
            step_ff  <= '0;
            state_ff <= DIVIDE;
         end
         DIVIDE: begin
            rem_ff  <= fits ? (rem_shift - div_ext) : rem_shift;
            quo_ff  <= {quo_ff[SUM_W-2:0], fits};
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_ff <= FINISH;
            end
         end
         FINISH: begin
            res_ff.done    <= 1'b1;
            res_ff.average <= avg_in;
            res_ff.rising  <= rising_in;
            res_ff.turn    <= have_ff && (rising_in != last_rising_ff);
            last_avg_ff    <= avg_in;
            last_rising_ff <= rising_in;
            state_ff       <= IDLE;
         end
         default: begin
            state_ff <= IDLE;
         end
      endcase
      if (reset) begin
         state_ff       <= IDLE;
         sum_ff         <= '0;
         last_avg_ff    <= '0;
         last_rising_ff <= 1'b1;
         res_ff.done    <= 1'b0;
      end
   end

   assign res = res_ff;

   a_start_nonzero_divisor : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> ctl.divisor != '0)
      else $error("lane started with a zero divisor");

endmodule
`default_nettype wire

FILE: hdl/dmat_merge.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dmat_merge
// Combine both lane results into one result transaction and hold it.
// -----------------------------------------------------------------------------
module dmat_merge import dmat_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lane_result_type front_res,
   input  wire lane_result_type rear_res,
   output      logic            pending,
   dmat_rsp_if.source           rsp_chan
);

   logic out_valid_ff;
   logic pend_ff;
   logic free;
   logic load;

   assign free = !out_valid_ff || rsp_chan.ready;
   assign load = (front_res.done || pend_ff) && free;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_chan.front_average <= front_res.average;
         rsp_chan.rear_average  <= rear_res.average;
         rsp_chan.front_rising  <= front_res.rising;
         rsp_chan.rear_rising   <= rear_res.rising;
         rsp_chan.front_turn    <= front_res.turn;
         rsp_chan.rear_turn     <= rear_res.turn;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= load || (out_valid_ff && !rsp_chan.ready);
         pend_ff      <= (front_res.done || pend_ff) && !free;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign pending        = pend_ff;

   a_pend_implies_full : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> out_valid_ff)
      else $error("result waiting while output register empty");

endmodule
`default_nettype wire

FILE: hdl/dual_moving_average_trend_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dual_moving_average_trend_top
// Windowed moving average of front and rear samples with trend flags.
//
//   channel    direction  transaction
//   req_chan   in         front_sample, rear_sample
//   rsp_chan   out        averages, rising and turn flags per side
//
// Each lane takes an accepted transaction through its ACCUM, MAGN, DIVIDE and
// FINISH states to the result register; the restoring divider in each lane
// retires one quotient bit per cycle.
// The next transaction is accepted once the lanes finish and the result
// register is free or being drained. Synchronous reset empties the window.
// -----------------------------------------------------------------------------
module dual_moving_average_trend_top import dmat_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   dmat_req_if.sink   req_chan,
   dmat_rsp_if.source rsp_chan
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type       state_ff;
   slot_type        slot_ff;
   count_type       fill_ff;
   logic            have_last_ff;
   logic            full;
   logic            accept;
   logic            pending;
   lane_start_type  ctl;
   lane_result_type front_res;
   lane_result_type rear_res;

   assign full             = (fill_ff == CNT_W'(WINDOW));
   assign req_chan.ready   = (state_ff == IDLE) && !pending;
   assign accept           = req_chan.valid && req_chan.ready;

   assign ctl.start     = accept;
   assign ctl.slot      = slot_ff;
   assign ctl.full      = full;
   assign ctl.divisor   = full ? CNT_W'(WINDOW) : (fill_ff + CNT_W'(1));
   assign ctl.have_last = have_last_ff;

   always_ff @(posedge clock) begin
      case (state_ff)
         IDLE: begin
            if (accept) begin
               slot_ff      <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0
                                                                : slot_ff + SLOT_W'(1);
               fill_ff      <= full ? fill_ff : fill_ff + CNT_W'(1);
               have_last_ff <= 1'b1;
               state_ff     <= RUN;
            end
         end
         RUN: begin
            if (front_res.done) begin
               state_ff <= IDLE;
            end
         end
         default: begin
            state_ff <= IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         have_last_ff <= 1'b0;
      end
   end

   dmat_lane u_front_lane (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_chan.front_sample),
      .res    (front_res)
   );

   dmat_lane u_rear_lane (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_chan.rear_sample),
      .res    (rear_res)
   );

   dmat_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .front_res (front_res),
      .rear_res  (rear_res),
      .pending   (pending),
      .rsp_chan  (rsp_chan)
   );

   a_lanes_in_step : assert property (@(posedge clock) disable iff (reset)
      front_res.done == rear_res.done)
      else $error("lanes finished out of step");

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_done_only_when_running : assert property (@(posedge clock) disable iff (reset)
      front_res.done |-> state_ff == RUN)
      else $error("lane result without a transaction in flight");

endmodule
`default_nettype wire

FILE: tb/sv/dual_moving_average_trend_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dual_moving_average_trend_top_tb
// Drives front and rear sample pairs into the averaging block and checks every
// result against a behavioural predictor of the windowed means and trend flags,
// or the table for rows marked fixed. A short table of corner cases runs first,
// followed by random spread, rail and drifting segments with bursty back-pressure.
// -----------------------------------------------------------------------------
module dual_moving_average_trend_top_tb import dmat_pkg::*;;

   localparam int RANDOM_ITEMS  = 830;
   localparam int TAIL_ITEMS    = 100;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      sample_type front_average;
      sample_type rear_average;
      logic       front_rising;
      logic       rear_rising;
      logic       front_turn;
      logic       rear_turn;
   } trend_result_type;

   typedef struct {
      int front;
      int rear;
      bit fixed;
      int front_avg;
      int rear_avg;
      bit front_up;
      bit rear_up;
      bit front_flip;
      bit rear_flip;
   } directed_row_type;

   typedef enum {MODE_SPREAD, MODE_RAILS, MODE_DRIFT} stim_mode_type;

   localparam int DIRECTED_ROWS = 18;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ 2047, -2048, 1'b1,  2047, -2048, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ 2047, -2048, 1'b1,  2047, -2048, 1'b1, 1'b1, 1'b0, 1'b0},
      '{-2048,  2047, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{-2048,  2047, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{    0,     0, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{   -1,     1, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{    1,    -1, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ 1365, -1366, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{-1366,  1365, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{   -7,     7, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{   -7,     7, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{  100,  -100, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{  100,  -100, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{   -1,    -1, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{    0,     0, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ 2047,  2047, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{-2048, -2048, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{    5,    -5, 1'b0,     0,     0, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   dmat_req_if req_chan ();
   dmat_rsp_if rsp_chan ();

   dual_moving_average_trend_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   int  front_hist [WINDOW];
   int  rear_hist [WINDOW];
   int  next_slot = 0;
   int  held = 0;
   int  front_total = 0;
   int  rear_total = 0;
   int  front_prev_mean = 0;
   int  rear_prev_mean = 0;
   bit  seen_any = 1'b0;
   bit  front_prev_up = 1'b1;
   bit  rear_prev_up = 1'b1;

   trend_result_type pending_averages [$];
   trend_result_type row_expect;
   bit               row_fixed = 1'b0;

   int  fault_count = 0;
   int  cycle_count = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   bit  tail_phase = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic trend_result_type predict_trend(sample_type f, sample_type r);
      trend_result_type res;
      int front_mean;
      int rear_mean;
      bit front_up;
      bit rear_up;
      if (held == WINDOW) begin
         front_total -= front_hist[next_slot];
         rear_total  -= rear_hist[next_slot];
      end else begin
         held++;
      end
      front_hist[next_slot] = int'(f);
      rear_hist[next_slot]  = int'(r);
      front_total += int'(f);
      rear_total  += int'(r);
      next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
      front_mean = front_total / held;
      rear_mean  = rear_total / held;
      front_up = !seen_any || (front_mean >= front_prev_mean);
      rear_up  = !seen_any || (rear_mean >= rear_prev_mean);
      res.front_average = sample_type'(front_mean);
      res.rear_average  = sample_type'(rear_mean);
      res.front_rising  = front_up;
      res.rear_rising   = rear_up;
      res.front_turn    = seen_any && (front_up != front_prev_up);
      res.rear_turn     = seen_any && (rear_up != rear_prev_up);
      front_prev_mean = front_mean;
      rear_prev_mean  = rear_mean;
      front_prev_up   = front_up;
      rear_prev_up    = rear_up;
      seen_any        = 1'b1;
      return res;
   endfunction

   function automatic int clamp_sample(int v);
      if (v > 2047)
         return 2047;
      if (v < -2048)
         return -2048;
      return v;
   endfunction

   task automatic log_fault(string text);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("[%0t] %s", $realtime, text);
   endtask

   task automatic send_sample(input int f, input int r, input bit fixed,
                              input trend_result_type want);
      @(negedge clock);
      if (!tail_phase && $urandom_range(99) < gap_pct) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(11, 1)) @(negedge clock);
      end
      req_chan.front_sample = sample_type'(f);
      req_chan.rear_sample  = sample_type'(r);
      row_fixed  = fixed;
      row_expect = want;
      req_chan.valid = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending_averages.size() != 0);
   endtask

   // result side: bursty back-pressure
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (!reset && !tail_phase && $urandom_range(99) < stall_pct) begin
            hold_left = $urandom_range(10, 0);
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      trend_result_type predicted;
      trend_result_type got;
      trend_result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predicted = predict_trend(req_chan.front_sample, req_chan.rear_sample);
            pending_averages.push_back(row_fixed ? row_expect : predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.front_average = rsp_chan.front_average;
            got.rear_average  = rsp_chan.rear_average;
            got.front_rising  = rsp_chan.front_rising;
            got.rear_rising   = rsp_chan.rear_rising;
            got.front_turn    = rsp_chan.front_turn;
            got.rear_turn     = rsp_chan.rear_turn;
            if (pending_averages.size() == 0) begin
               log_fault($sformatf("unexpected transaction: avg %0d/%0d", got.front_average,
                                   got.rear_average));
            end else begin
               want = pending_averages.pop_front();
               if (got !== want)
                  log_fault($sformatf({"mismatch: expected avg %0d/%0d rise %b/%b turn %b/%b,",
                                       " got avg %0d/%0d rise %b/%b turn %b/%b"},
                                      want.front_average, want.rear_average,
                                      want.front_rising, want.rear_rising,
                                      want.front_turn, want.rear_turn,
                                      got.front_average, got.rear_average,
                                      got.front_rising, got.rear_rising,
                                      got.front_turn, got.rear_turn));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      trend_result_type want;
      stim_mode_type    mode;
      int sent;
      int seg_len;
      int level_f;
      int level_r;
      int dir_f;
      int dir_r;
      int rail_f;
      int rail_r;
      int f;
      int r;
      bit mid_drained;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.front_sample = '0;
      req_chan.rear_sample = '0;
      sent = 0;
      level_f = 0;
      level_r = 0;
      dir_f = 1;
      dir_r = -1;
      mid_drained = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gap_pct = 20;
      stall_pct = 20;
      foreach (directed_rows[i]) begin
         want.front_average = sample_type'(directed_rows[i].front_avg);
         want.rear_average  = sample_type'(directed_rows[i].rear_avg);
         want.front_rising  = directed_rows[i].front_up;
         want.rear_rising   = directed_rows[i].rear_up;
         want.front_turn    = directed_rows[i].front_flip;
         want.rear_turn     = directed_rows[i].rear_flip;
         send_sample(directed_rows[i].front, directed_rows[i].rear,
                     directed_rows[i].fixed, want);
      end

      // hold until the block has emptied
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait_drained();

      want = '0;
      while (sent < RANDOM_ITEMS) begin
         if (!mid_drained && sent >= RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            wait_drained();
            mid_drained = 1'b1;
         end
         mode = stim_mode_type'($urandom_range(2));
         gap_pct = 15 * $urandom_range(3);
         stall_pct = 15 * $urandom_range(3);
         if (mode == MODE_RAILS) begin
            seg_len = $urandom_range(160, 125);
            rail_f = $urandom_range(1) ? 2047 : -2048;
            rail_r = $urandom_range(1) ? 2047 : -2048;
         end else begin
            seg_len = $urandom_range(160, 20);
         end
         repeat (seg_len) begin
            if (sent < RANDOM_ITEMS) begin
               tail_phase = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
               case (mode)
                  MODE_SPREAD: begin
                     f = int'(sample_type'($urandom_range(4095)));
                     r = int'(sample_type'($urandom_range(4095)));
                  end
                  MODE_RAILS: begin
                     f = rail_f;
                     r = rail_r;
                  end
                  default: begin
                     if ($urandom_range(99) < 5 || level_f > 1900 || level_f < -1900)
                        dir_f = -dir_f;
                     if ($urandom_range(99) < 5 || level_r > 1900 || level_r < -1900)
                        dir_r = -dir_r;
                     level_f = clamp_sample(level_f + dir_f * $urandom_range(30));
                     level_r = clamp_sample(level_r + dir_r * $urandom_range(30));
                     f = clamp_sample(level_f + $urandom_range(20) - 10);
                     r = clamp_sample(level_r + $urandom_range(20) - 10);
                  end
               endcase
               send_sample(f, r, 1'b0, want);
               sent++;
            end
         end
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fault_count == 0 && pending_averages.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
